// File: sv/psg_pkg.sv
// Package for the three-channel sound generator.
// Types, constants and tables shared by controller, datapath and top level.
package psg_pkg;

	localparam int unsigned SampleRate = 15600;
	localparam int unsigned ToneClock = 1773400;
	localparam int unsigned NoiseClock = 1773400;
	localparam int unsigned EnvClock = 69270;
	localparam int unsigned EnvThresh = SampleRate * 10 / 16;

	localparam logic [1:0] CMD_SELECT = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	localparam logic [1:0] CFG_CHIP = 2'd0;
	localparam logic [1:0] CFG_SPEECH = 2'd1;
	localparam logic [1:0] CFG_ENV = 2'd2;

	// Divider kinds.
	typedef enum logic [1:0] {
		DIV_TONE = 2'd0,
		DIV_NOISE = 2'd1,
		DIV_ENV = 2'd2
	} div_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_DIV = 3'd1,
		ST_DIV_DONE = 3'd2,
		ST_TICK = 3'd3,
		ST_MIX = 3'd4,
		ST_OUT = 3'd5
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic div_start;
		logic div_step;
		logic div_store;
		logic advance;
		logic mix;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic div_busy;
		logic needs_div;
	} dp_status_t;

	function automatic logic [4:0] vol_lookup(input logic [3:0] v);
		logic [4:0] r;
		case (v)
			4'd0, 4'd1: r = 5'd0;
			4'd2, 4'd3, 4'd4: r = 5'd1;
			4'd5, 4'd6: r = 5'd2;
			4'd7: r = 5'd3;
			4'd8: r = 5'd4;
			4'd9: r = 5'd6;
			4'd10: r = 5'd8;
			4'd11: r = 5'd10;
			4'd12: r = 5'd14;
			4'd13: r = 5'd16;
			4'd14: r = 5'd20;
			default: r = 5'd24;
		endcase
		return r;
	endfunction

endpackage

// File: sv/psg_ctrl.sv
// Controller state machine for the sound generator.
// Uses psg_pkg for state and command types; drives the datapath.
module psg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            in_cmd,
	input  logic                  chip_en,
	output logic                  out_valid,
	input  logic                  out_stall,
	output psg_pkg::dp_cmd_t      cmd,
	input  psg_pkg::dp_status_t   status
);

	psg_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		take = 1'b0;
		case (state_q)
			psg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				take = in_valid;
				if (take) begin
					if (in_cmd == psg_pkg::CMD_WRITE && status.needs_div) begin
						cmd.div_start = 1'b1;
						state_d = psg_pkg::ST_DIV;
					end else if (in_cmd == psg_pkg::CMD_TICK && chip_en) begin
						state_d = psg_pkg::ST_TICK;
					end else begin
						state_d = psg_pkg::ST_OUT;
					end
				end
			end
			psg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (!status.div_busy) state_d = psg_pkg::ST_DIV_DONE;
			end
			psg_pkg::ST_DIV_DONE: begin
				cmd.div_store = 1'b1;
				state_d = psg_pkg::ST_OUT;
			end
			psg_pkg::ST_TICK: begin
				cmd.advance = 1'b1;
				state_d = psg_pkg::ST_MIX;
			end
			psg_pkg::ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = psg_pkg::ST_OUT;
			end
			psg_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = psg_pkg::ST_IDLE;
				end
			end
			default: state_d = psg_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: sv/psg_divider.sv
// Restoring divider, one quotient bit per step: 21-bit dividend by a 20-bit divisor.
// Uses no package items; shared by all increment computations.
module psg_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [20:0] dividend,
	input  logic [19:0] divisor,
	output logic        busy,
	output logic [20:0] quotient
);

	logic [20:0] quo_q;
	logic [20:0] rem_q;
	logic [19:0] dvs_q;
	logic [4:0]  cnt_q;
	logic [21:0] trial;
	logic [21:0] shifted;

	assign shifted = {rem_q, quo_q[20]};
	assign trial = shifted - {2'b00, dvs_q};
	assign busy = (cnt_q != 5'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd21;
		end else if (step && busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step && busy) begin
			if (!trial[21]) begin
				rem_q <= trial[20:0];
				quo_q <= {quo_q[19:0], 1'b1};
			end else begin
				rem_q <= shifted[20:0];
				quo_q <= {quo_q[19:0], 1'b0};
			end
		end
	end

endmodule

// File: sv/psg_datapath.sv
// Datapath: register file, generators, envelope, mixer and output register.
// Uses psg_pkg and the psg_divider unit.
module psg_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [1:0]            in_cmd,
	input  logic [7:0]            in_data,
	input  logic                  speech_en,
	input  logic                  env_en,
	input  psg_pkg::dp_cmd_t      cmd,
	output psg_pkg::dp_status_t   status,
	output logic [7:0]            read_data,
	output logic signed [7:0]     sample
);

	logic [7:0]  regs_q [16];
	logic [3:0]  sel_q;
	logic [13:0] tinc_q [3];
	logic [14:0] tph_q [3];
	logic [2:0]  tlev_q;
	logic [13:0] ninc_q;
	logic [14:0] nph_q;
	logic [15:0] ngen_q;
	logic        nlev_q;
	logic [13:0] einc_q;
	logic [14:0] eph_q;
	logic [5:0]  estep_q;
	logic        edir_q;
	logic [3:0]  evol_q;
	logic [1:0]  kind_q;
	logic [1:0]  ch_q;
	logic [1:0]  pend_cmd_q;
	logic [7:0]  rd_q;
	logic signed [7:0] acc_q;
	logic [7:0]  rd_out_q;
	logic signed [7:0] smp_out_q;

	logic [3:0]  r;
	assign r = sel_q;

	// Divider operands chosen from the register being written.
	logic [20:0] dividend;
	logic [19:0] divisor;
	logic [1:0]  wch;
	logic [7:0]  fine, coarse;
	logic        div_busy;
	logic [20:0] quo;

	assign wch = r[2:1];
	always_comb begin
		fine = (wch == 2'd0) ? regs_q[0] : (wch == 2'd1) ? regs_q[2] : regs_q[4];
		coarse = (wch == 2'd0) ? regs_q[1] : (wch == 2'd1) ? regs_q[3] : regs_q[5];
		if (r == 4'd1 || r == 4'd3 || r == 4'd5) coarse = in_data;
		if (r == 4'd0 || r == 4'd2 || r == 4'd4) fine = in_data;
		dividend = 21'(psg_pkg::ToneClock);
		divisor = {4'd0, coarse[3:0], fine, 4'b0000};
		if (r == 4'd6) begin
			dividend = 21'(psg_pkg::NoiseClock);
			divisor = {11'd0, in_data[4:0], 4'b0000};
		end else if (r == 4'd11 || r == 4'd12) begin
			dividend = 21'(psg_pkg::EnvClock);
			divisor = (r == 4'd11) ? {4'd0, regs_q[12], in_data}
			                       : {4'd0, in_data, regs_q[11]};
		end
		if (divisor == 20'd0) divisor = 20'd1;
	end

	assign status.needs_div = (r <= 4'd6) || (r == 4'd11) || (r == 4'd12);
	assign status.div_busy = div_busy;

	psg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Cap and adjust the quotient.
	logic [21:0] qv;
	logic [13:0] inc_new;
	always_comb begin
		qv = (kind_q == psg_pkg::DIV_NOISE) ? {quo, 1'b0} : {1'b0, quo};
		if (qv > 22'(psg_pkg::SampleRate)) qv = 22'(psg_pkg::SampleRate);
		if (qv == 22'(psg_pkg::SampleRate)) begin
			if (kind_q == psg_pkg::DIV_ENV) qv = 22'(psg_pkg::SampleRate * 2 / 3);
			else qv = 22'(psg_pkg::SampleRate - 10);
		end
		inc_new = qv[13:0];
	end

	// Envelope step logic.
	logic [3:0] shape, es;
	logic [3:0] env_v;
	logic [5:0] estep_n;
	logic       edir_n;
	always_comb begin
		shape = regs_q[13][3:0];
		es = estep_q[3:0];
		estep_n = estep_q;
		edir_n = edir_q;
		case (shape)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd11: env_v = 4'd15 - es;
			4'd10: env_v = edir_q ? 4'd15 - es : es;
			4'd14: env_v = edir_q ? es : 4'd15 - es;
			default: env_v = es;
		endcase
		if (estep_q[4]) env_v = 4'd0;
		else if (estep_q[5]) env_v = 4'd15;
		else if (es == 4'd15) begin
			case (shape)
				4'd11, 4'd13: estep_n = 6'd32;
				4'd8, 4'd10, 4'd12, 4'd14: begin
					estep_n = 6'd0;
					if (shape == 4'd10 || shape == 4'd14) edir_n = ~edir_q;
				end
				default: estep_n = 6'd16;
			endcase
		end else begin
			estep_n = {2'b00, es + 4'd1};
		end
	end

	// Mixer: all three channels are signed, scaled and summed combinationally.
	logic signed [7:0] mix_sum;
	always_comb begin
		logic signed [7:0] s;
		logic tone_on, noise_on;
		logic signed [1:0] sg;
		logic [7:0] vreg;
		logic [3:0] vol;
		s = '0;
		for (int c = 0; c < 3; c++) begin
			tone_on = !regs_q[7][c];
			noise_on = !regs_q[7][c + 3];
			if (tone_on && noise_on)
				sg = (tlev_q[c] == nlev_q) ? (tlev_q[c] ? 2'sd1 : -2'sd1) : 2'sd0;
			else if (tone_on) sg = tlev_q[c] ? 2'sd1 : -2'sd1;
			else if (noise_on) sg = nlev_q ? 2'sd1 : -2'sd1;
			else sg = speech_en ? 2'sd1 : 2'sd0;
			vreg = regs_q[8 + c];
			if (vreg[4]) vol = env_en ? evol_q : 4'd15;
			else vol = vreg[3:0];
			if (sg == 2'sd1) s = s + 8'(psg_pkg::vol_lookup(vol));
			else if (sg == -2'sd1) s = s - 8'(psg_pkg::vol_lookup(vol));
		end
		mix_sum = s;
	end

	logic [15:0] ngen_next;
	logic [22:0] ngen_mul;
	assign ngen_mul = 23'(ngen_q + 17'd1) * 23'd75 - 23'd1;
	assign ngen_next = ngen_mul[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) regs_q[i] <= 8'hFF;
			sel_q <= '0;
			for (int i = 0; i < 3; i++) begin
				tinc_q[i] <= '0;
				tph_q[i] <= '0;
			end
			tlev_q <= 3'b111;
			ninc_q <= '0;
			nph_q <= '0;
			ngen_q <= '0;
			nlev_q <= 1'b1;
			einc_q <= '0;
			eph_q <= '0;
			estep_q <= '0;
			edir_q <= 1'b1;
			evol_q <= '0;
			kind_q <= psg_pkg::DIV_TONE;
			ch_q <= '0;
			pend_cmd_q <= psg_pkg::CMD_SELECT;
			rd_q <= 8'hFF;
			acc_q <= '0;
		end else begin
			if (take) begin
				pend_cmd_q <= in_cmd;
				rd_q <= (in_cmd == psg_pkg::CMD_READ) ? regs_q[r] : 8'hFF;
				acc_q <= '0;
				case (in_cmd)
					psg_pkg::CMD_SELECT: sel_q <= in_data[3:0];
					psg_pkg::CMD_WRITE: begin
						regs_q[r] <= in_data;
						if (r == 4'd13) estep_q <= '0;
						ch_q <= wch;
						if (r == 4'd6) kind_q <= psg_pkg::DIV_NOISE;
						else if (r == 4'd11 || r == 4'd12) kind_q <= psg_pkg::DIV_ENV;
						else kind_q <= psg_pkg::DIV_TONE;
					end
					default: ;
				endcase
			end
			if (cmd.div_store) begin
				case (kind_q)
					psg_pkg::DIV_NOISE: ninc_q <= inc_new;
					psg_pkg::DIV_ENV: einc_q <= inc_new;
					default: tinc_q[ch_q] <= inc_new;
				endcase
			end
			if (cmd.advance) begin
				logic [15:0] sm;
				for (int c = 0; c < 3; c++) begin
					tlev_q[c] <= (tph_q[c] < 15'(psg_pkg::SampleRate / 2));
					sm = {1'b0, tph_q[c]} + {2'b00, tinc_q[c]};
					if (sm >= 16'(psg_pkg::SampleRate)) sm = sm - 16'(psg_pkg::SampleRate);
					tph_q[c] <= sm[14:0];
				end
				sm = {1'b0, nph_q} + {2'b00, ninc_q};
				if (sm >= 16'(psg_pkg::SampleRate)) begin
					sm = sm - 16'(psg_pkg::SampleRate);
					ngen_q <= ngen_next;
					nlev_q <= !ngen_next[15];
				end
				nph_q <= sm[14:0];
				sm = {1'b0, eph_q} + {2'b00, einc_q};
				if (sm >= 16'(psg_pkg::EnvThresh)) begin
					sm = sm - 16'(psg_pkg::EnvThresh);
					evol_q <= env_v;
					estep_q <= estep_n;
					edir_q <= edir_n;
				end
				eph_q <= sm[15] ? 15'h7FFF : sm[14:0];
			end
			if (cmd.mix) acc_q <= mix_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rd_out_q <= rd_q;
			smp_out_q <= (pend_cmd_q == psg_pkg::CMD_TICK) ? acc_q : 8'sd0;
		end
	end

	assign read_data = rd_out_q;
	assign sample = smp_out_q;

endmodule

// File: sv/psg_three_channel_sound_generator.sv
// Top level of the three-channel sound generator.
// Joins psg_ctrl and psg_datapath; uses psg_pkg and holds the config bits.
//
// Usage: the input channel (in_valid/in_stall) carries one bus command per
// transfer: cmd selects a register, writes the selected register, reads it,
// or issues a sample tick; bus_data is the register number or data byte.
// Every transfer produces exactly one result transfer on out_valid/out_stall,
// with read_data (register value on a read, else 255) and sample (summed
// signed channel level after a tick with the chip enabled, else 0).
// Sequence: select, read and plain writes go from ST_IDLE to ST_OUT, which
// loads the result into the output register; a tick with the chip enabled
// passes ST_TICK (advance) and ST_MIX (mix) first; a write to a period
// register passes ST_DIV and ST_DIV_DONE because the phase increment is
// computed by the shared restoring divider at one quotient bit per cycle
// (21 steps in ST_DIV, which then sees it done; ST_DIV_DONE stores the result
// and ST_OUT loads it). The next item waits until the previous result has
// been loaded into the output register.
// Reset: all registers read 255, increments and phases are zero, and the
// configuration bits return to chip and envelope enabled, speech disabled.
// When the receiver stalls, the result holds and the block accepts at most
// one further item, which it finishes and then holds until the output frees.
module psg_three_channel_sound_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [7:0]        bus_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        read_data,
	output logic signed [7:0] sample,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [0:0]        cfg_data
);

	logic chip_en_q, speech_en_q, env_en_q;
	psg_pkg::dp_cmd_t dp_cmd;
	psg_pkg::dp_status_t dp_status;
	logic take;

	assign cfg_ready = 1'b1;

	// Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_en_q <= 1'b1;
			speech_en_q <= 1'b0;
			env_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				psg_pkg::CFG_CHIP: chip_en_q <= cfg_data[0];
				psg_pkg::CFG_SPEECH: speech_en_q <= cfg_data[0];
				psg_pkg::CFG_ENV: env_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign take = in_valid && !in_stall;

	psg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_cmd    (cmd),
		.chip_en   (chip_en_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	psg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_cmd    (cmd),
		.in_data   (bus_data),
		.speech_en (speech_en_q),
		.env_en    (env_en_q),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.read_data (read_data),
		.sample    (sample)
	);

endmodule
